FILE: hw/rtl/bdc_pkg.sv
`default_nettype none
package bdc_pkg;

  // pixel and coded byte width
  localparam int PIX_W = 8;

  // default row store depth, largest supported block side
  localparam int DEFAULT_MAX_BLOCK_WIDTH = 64;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DECODE_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUANT_STEP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIDPOINT_RECON = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH    = 2'd3;

  // block width register width
  localparam int BW_REG_W = 7;

  // reset values of the configuration registers
  localparam logic [PIX_W-1:0]    QUANT_STEP_RESET  = 8'd1;
  localparam logic [BW_REG_W-1:0] BLOCK_WIDTH_RESET = 7'd8;

endpackage
`default_nettype wire

FILE: hw/rtl/bdc_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
module bdc_div
  import bdc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [PIX_W-1:0] dividend,
  input  wire logic [PIX_W-1:0] divisor,
  output logic                  done,
  output logic [PIX_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(PIX_W + 1);

  logic [PIX_W-1:0] rem;
  logic [PIX_W-1:0] dvd;
  logic [PIX_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  logic [PIX_W:0] rem_shift;
  logic           q_bit;

  // one trial subtraction
  always_comb begin
    rem_shift = {rem, dvd[PIX_W-1]};
    q_bit     = (rem_shift >= {1'b0, dvs});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(PIX_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, quotient shifts into the dividend register
  // remainder stays below the divisor, so it fits in PIX_W bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= q_bit ? PIX_W'(rem_shift - {1'b0, dvs}) : rem_shift[PIX_W-1:0];
      dvd <= {dvd[PIX_W-2:0], q_bit};
    end
  end

  assign quotient = dvd;

endmodule
`default_nettype wire

FILE: hw/rtl/block_dpcm_deadzone_codec.sv
`default_nettype none
// per pixel: input transfer in S_IDLE, then S_PRED and S_REC for block start and lossless
//   encode, S_PRED, S_MUL and S_REC for decode, S_PRED, S_DIV (bit-serial divider),
//   S_MUL and S_REC for lossy encode; one pixel at a time, next input taken the cycle
//   after the result is loaded into the output register
// reset: synchronous, clears config to defaults, position counters and left pixel;
//   row store contents are not cleared
module block_dpcm_deadzone_codec
  import bdc_pkg::*;
#(
  parameter int MAX_BLOCK_WIDTH = DEFAULT_MAX_BLOCK_WIDTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input stream
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [7:0]           s_tdata,   // [7:0] sample
  // output stream
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [15:0]               m_tdata,   // [7:0] coded_value, [15:8] recon_value
  output logic                      m_tlast,   // block_last
  output logic                      m_tuser,   // [0] block_start
  // configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  localparam int CW    = (MAX_BLOCK_WIDTH > 1) ? $clog2(MAX_BLOCK_WIDTH) : 1;
  localparam int CMP_W = (CW + 1 > BW_REG_W) ? CW + 1 : BW_REG_W;
  localparam int PROD_W = 2 * PIX_W;
  localparam int SUM_W  = PROD_W + 2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PRED = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_REC  = 3'd4;

  // configuration registers
  logic                decode_mode;
  logic [PIX_W-1:0]    quant_step;
  logic                midpoint_recon;
  logic [BW_REG_W-1:0] block_width;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode    <= 1'b0;
      quant_step     <= QUANT_STEP_RESET;
      midpoint_recon <= 1'b0;
      block_width    <= BLOCK_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DECODE_MODE:    decode_mode    <= cfg_data[0];
        REG_QUANT_STEP:     quant_step     <= cfg_data;
        REG_MIDPOINT_RECON: midpoint_recon <= cfg_data[0];
        REG_BLOCK_WIDTH:    block_width    <= cfg_data[BW_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective step, offset and block width
  logic [PIX_W-1:0] qs_eff;
  logic [PIX_W-1:0] offset;
  logic [CMP_W-1:0] bw_ext;
  logic [CMP_W-1:0] bw_eff;

  always_comb begin
    qs_eff = (quant_step == '0) ? PIX_W'(1) : quant_step;
    offset = midpoint_recon ? (qs_eff >> 1) : '0;
    bw_ext = CMP_W'(block_width);
    if (bw_ext == '0) begin
      bw_eff = CMP_W'(1);
    end else if (bw_ext > CMP_W'(MAX_BLOCK_WIDTH)) begin
      bw_eff = CMP_W'(MAX_BLOCK_WIDTH);
    end else begin
      bw_eff = bw_ext;
    end
  end

  // state
  logic [2:0]       state;
  logic [CW-1:0]    col_in_block;
  logic [CW-1:0]    row_in_block;
  logic [PIX_W-1:0] left_recon;

  // per pixel registers
  logic [PIX_W-1:0] smp;
  logic [CW-1:0]    cur_col;
  logic [CW-1:0]    cur_row;
  logic [CMP_W-1:0] cur_bw;
  logic             cur_start;
  logic             cur_last;
  logic [PIX_W-1:0] pred;
  logic             neg;
  logic             direct;
  logic [PIX_W-1:0] direct_recon;
  logic [PIX_W-1:0] coded;
  logic [PIX_W-1:0] qmag;
  logic [PROD_W-1:0] prod;

  logic in_xfer;
  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;

  // position of the arriving pixel, restarting a block if out of range
  logic          wrap;
  logic [CW-1:0] pos_col;
  logic [CW-1:0] pos_row;
  logic          pos_start;
  logic          pos_last;

  always_comb begin
    wrap      = (CMP_W'(col_in_block) >= bw_eff) || (CMP_W'(row_in_block) >= bw_eff);
    pos_col   = wrap ? '0 : col_in_block;
    pos_row   = wrap ? '0 : row_in_block;
    pos_start = (pos_col == '0) && (pos_row == '0);
    pos_last  = (CMP_W'(pos_col) == bw_eff - 1'b1) && (CMP_W'(pos_row) == bw_eff - 1'b1);
  end

  // row store, read at transfer, written back at reconstruction
  logic [PIX_W-1:0] row_mem [MAX_BLOCK_WIDTH];
  logic [PIX_W-1:0] row_rd;
  logic             mem_we;
  logic [PIX_W-1:0] recon;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_mem[cur_col] <= recon;
    end
    if (in_xfer) begin
      row_rd <= row_mem[pos_col];
    end
  end

  // prediction error
  logic [PIX_W-1:0] pred_sel;
  logic [PIX_W:0]   err;
  logic [PIX_W-1:0] err_mag;
  logic [PIX_W-1:0] idx_mag;

  always_comb begin
    pred_sel = (cur_row == '0) ? left_recon : row_rd;
    err      = {1'b0, smp} - {1'b0, pred_sel};
    err_mag  = err[PIX_W] ? PIX_W'(~err + 1'b1) : err[PIX_W-1:0];
    idx_mag  = smp[PIX_W-1] ? (~smp + 1'b1) : smp;
  end

  // divider
  logic             div_start;
  logic             div_done;
  logic [PIX_W-1:0] div_q;

  assign div_start = (state == S_PRED) && !cur_start && !decode_mode && (qs_eff > PIX_W'(1));

  bdc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (err_mag),
    .divisor  (qs_eff),
    .done     (div_done),
    .quotient (div_q)
  );

  // reconstruction with offset and clamp
  logic [PROD_W:0]  mag_total;
  logic [SUM_W-1:0] sum;

  always_comb begin
    mag_total = {1'b0, prod} + ((prod != '0) ? (PROD_W+1)'(offset) : '0);
    if (neg) begin
      sum = SUM_W'(pred) - SUM_W'(mag_total);
    end else begin
      sum = SUM_W'(pred) + SUM_W'(mag_total);
    end
    if (direct) begin
      recon = direct_recon;
    end else if (sum[SUM_W-1]) begin
      recon = '0;
    end else if (sum > SUM_W'(255)) begin
      recon = 8'd255;
    end else begin
      recon = sum[PIX_W-1:0];
    end
  end

  logic finish;
  assign finish = (state == S_REC) && (!m_tvalid || m_tready);
  assign mem_we = finish;

  // next position
  logic [CMP_W-1:0] col_inc;
  logic [CMP_W-1:0] row_inc;
  assign col_inc = CMP_W'(cur_col) + 1'b1;
  assign row_inc = CMP_W'(cur_row) + 1'b1;

  // sequencer and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      col_in_block <= '0;
      row_in_block <= '0;
      left_recon   <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !finish) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) state <= S_PRED;
        end
        S_PRED: begin
          if (cur_start || (!decode_mode && !(qs_eff > PIX_W'(1)))) begin
            state <= S_REC;
          end else if (decode_mode) begin
            state <= S_MUL;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) state <= S_MUL;
        end
        S_MUL: begin
          state <= S_REC;
        end
        S_REC: begin
          if (finish) begin
            state      <= S_IDLE;
            m_tvalid   <= 1'b1;
            left_recon <= recon;
            if (col_inc >= cur_bw) begin
              col_in_block <= '0;
              row_in_block <= (row_inc >= cur_bw) ? '0 : row_inc[CW-1:0];
            end else begin
              col_in_block <= col_inc[CW-1:0];
              row_in_block <= cur_row;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // per pixel datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      smp       <= s_tdata;
      cur_col   <= pos_col;
      cur_row   <= pos_row;
      cur_bw    <= bw_eff;
      cur_start <= pos_start;
      cur_last  <= pos_last;
    end
    if (state == S_PRED) begin
      pred         <= pred_sel;
      direct_recon <= smp;
      if (cur_start) begin
        direct <= 1'b1;
        coded  <= '0;
      end else if (decode_mode) begin
        direct <= 1'b0;
        coded  <= smp;
        qmag   <= idx_mag;
        neg    <= smp[PIX_W-1];
      end else if (qs_eff > PIX_W'(1)) begin
        direct <= 1'b0;
        neg    <= err[PIX_W];
      end else begin
        direct <= 1'b1;
        coded  <= err[PIX_W-1:0];
      end
    end
    if ((state == S_DIV) && div_done) begin
      qmag  <= div_q;
      coded <= neg ? (~div_q + 1'b1) : div_q;
    end
    if (state == S_MUL) begin
      prod <= qmag * qs_eff;
    end
    if (finish) begin
      m_tdata <= {recon, coded};
      m_tlast <= cur_last;
      m_tuser <= cur_start;
    end
  end

endmodule
`default_nettype wire
